FILE: hw/rtl/voc_block_header_parser_assert.svh
// Assertion macros shared by the parser modules.
`ifndef VOC_BLOCK_HEADER_PARSER_ASSERT_SVH
`define VOC_BLOCK_HEADER_PARSER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define VBHP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define VBHP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/vbhp_pkg.sv
// Types, constants and codes shared by the block header parser.
package vbhp_pkg;

    localparam int unsigned SIG_LEN = 19;
    localparam logic [31:0] DATA_START = 32'd26;
    localparam logic [16:0] CODEC_NONE = 17'h1FFFF;
    localparam logic [27:0] RATE_NUM_SMALL = 28'd1000000;
    localparam logic [27:0] RATE_NUM_LARGE = 28'd256000000;
    localparam logic [4:0] DIV_STEPS = 5'd28;

    localparam logic [7:0] SIG_BYTES [SIG_LEN] = '{
        8'h43, 8'h72, 8'h65, 8'h61, 8'h74, 8'h69, 8'h76, 8'h65, 8'h20, 8'h56,
        8'h6F, 8'h69, 8'h63, 8'h65, 8'h20, 8'h46, 8'h69, 8'h6C, 8'h65
    };

    // Block type codes.
    localparam logic [7:0] BT_END = 8'd0;
    localparam logic [7:0] BT_SOUND = 8'd1;
    localparam logic [7:0] BT_CONT = 8'd2;
    localparam logic [7:0] BT_SILENCE = 8'd3;
    localparam logic [7:0] BT_MARKER = 8'd4;
    localparam logic [7:0] BT_TEXT = 8'd5;
    localparam logic [7:0] BT_REP_START = 8'd6;
    localparam logic [7:0] BT_REP_END = 8'd7;
    localparam logic [7:0] BT_EXTENDED = 8'd8;
    localparam logic [7:0] BT_SOUND_NEW = 8'd9;

    // Codec codes that give a sample size.
    localparam logic [16:0] CODEC_PCM8 = 17'd0;
    localparam logic [16:0] CODEC_PCM16 = 17'd4;

    // Header phases.
    localparam logic [2:0] PH_TYPE = 3'd0;
    localparam logic [2:0] PH_DATA = 3'd4;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       last_byte;
    } vbhp_in_t;

    typedef struct packed {
        logic               accepted;
        logic               format_ok;
        logic [31:0]        sample_rate;
        logic [8:0]         channel_count;
        logic [7:0]         sample_bits;
        logic signed [31:0] sample_length;
        logic signed [31:0] loop_start;
        logic signed [31:0] loop_end;
    } vbhp_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_LOAD,
        ST_START,
        ST_DIVIDE,
        ST_COMMIT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic step;
        logic load;
        logic div_start;
        logic commit;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic commit_pend;
        logic last_pend;
        logic need_div;
        logic div_busy;
        logic out_full;
    } status_t;

endpackage

FILE: hw/rtl/vbhp_div.sv
// Radix-2 restoring divider for the sample rate quotients.
module vbhp_div
    import vbhp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [27:0] dividend,
    input  logic [24:0] divisor,
    output logic        busy,
    output logic [27:0] quotient
);

    logic        busy_reg, busy_next;
    logic [4:0]  count_reg, count_next;
    logic [24:0] rem_reg, rem_next;
    logic [27:0] quo_reg, quo_next;
    logic [25:0] shifted;
    logic [26:0] trial;

    // One quotient bit per cycle.
    always_comb
    begin
        shifted = {rem_reg, quo_reg[27]};
        trial = {1'b0, shifted} - {2'b00, divisor};
        busy_next = busy_reg;
        count_next = count_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            count_next = DIV_STEPS;
            rem_next = '0;
            quo_next = dividend;
        end
        else if (busy_reg)
        begin
            if (!trial[26])
                rem_next = trial[24:0];
            else
                rem_next = shifted[24:0];
            quo_next = {quo_reg[26:0], ~trial[26]};
            count_next = count_reg - 5'd1;
            if (count_reg == 5'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign busy = busy_reg;
    assign quotient = quo_reg;

endmodule

FILE: hw/rtl/vbhp_dp.sv
// Datapath: byte parsing, block commit, divider and result register.
module vbhp_dp
    import vbhp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_t      cmd,
    input  vbhp_in_t  in_item,
    input  logic      out_ready,
    output status_t   status,
    output logic      out_valid,
    output vbhp_out_t out_item
);

`include "voc_block_header_parser_assert.svh"

    logic [31:0] pos_reg, pos_next;
    logic        sig_reg, sig_next;
    logic [7:0]  hdr_reg [3];
    logic [7:0]  hdr_next [3];
    logic [7:0]  type_reg, type_next;
    logic [23:0] remain_reg, remain_next;
    logic [3:0]  idx_reg, idx_next;
    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  field_reg [8];
    logic [7:0]  field_next [8];
    logic [16:0] codec_reg, codec_next;
    logic [31:0] rate_reg, rate_next;
    logic [8:0]  chan_reg, chan_next;
    logic [7:0]  bits_reg, bits_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] ls_reg, ls_next;
    logic [31:0] le_reg, le_next;
    logic        okay_reg, okay_next;
    logic        stop_reg, stop_next;
    logic        cpend_reg, cpend_next;
    logic        lpend_reg, lpend_next;
    logic        ovalid_reg, ovalid_next;
    vbhp_out_t   oitem_reg, oitem_next;
    logic [27:0] dvd_reg;
    logic [24:0] dvs_reg;
    logic        div_busy;
    logic [27:0] quotient;
    logic [31:0] size32;
    logic [8:0]  ch8;
    logic [16:0] period;
    logic [24:0] product;
    logic [16:0] silence;
    logic [16:0] new_codec;
    logic [7:0]  b;

    vbhp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dvd_reg),
        .divisor  (dvs_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    assign b = in_item.file_byte;
    assign size32 = {8'd0, hdr_reg[2], hdr_reg[1], hdr_reg[0]};
    assign ch8 = {1'b0, field_reg[3]} + 9'd1;
    assign period = 17'h10000 - {1'b0, field_reg[1], field_reg[0]};
    assign product = 25'(ch8 * period);
    assign silence = 17'd1 + {1'b0, field_reg[1], field_reg[0]};

    // Divisor and dividend for the current block type.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            if (type_reg == BT_EXTENDED)
            begin
                dvd_reg <= RATE_NUM_LARGE;
                dvs_reg <= product;
            end
            else if (type_reg == BT_SILENCE)
            begin
                dvd_reg <= RATE_NUM_SMALL;
                dvs_reg <= 25'h100 - {17'd0, field_reg[2]};
            end
            else
            begin
                dvd_reg <= RATE_NUM_SMALL;
                dvs_reg <= 25'h100 - {17'd0, field_reg[0]};
            end
        end
    end

    // Next state of the parse: byte step, block commit, or end of file.
    always_comb
    begin
        pos_next = pos_reg;
        sig_next = sig_reg;
        hdr_next = hdr_reg;
        type_next = type_reg;
        remain_next = remain_reg;
        idx_next = idx_reg;
        phase_next = phase_reg;
        field_next = field_reg;
        codec_next = codec_reg;
        rate_next = rate_reg;
        chan_next = chan_reg;
        bits_next = bits_reg;
        len_next = len_reg;
        ls_next = ls_reg;
        le_next = le_reg;
        okay_next = okay_reg;
        stop_next = stop_reg;
        cpend_next = cpend_reg;
        lpend_next = lpend_reg;
        ovalid_next = ovalid_reg;
        oitem_next = oitem_reg;
        new_codec = '0;

        if (ovalid_reg && out_ready)
            ovalid_next = 1'b0;

        if (cmd.step)
        begin
            cpend_next = 1'b0;
            lpend_next = in_item.last_byte;
            if (pos_reg < 32'(SIG_LEN))
            begin
                if (b != SIG_BYTES[pos_reg[4:0]])
                    sig_next = 1'b0;
            end
            else if (pos_reg >= DATA_START && sig_reg && !stop_reg)
            begin
                if (phase_reg == PH_TYPE)
                begin
                    if (b == BT_END)
                        stop_next = 1'b1;
                    else
                    begin
                        type_next = b;
                        phase_next = 3'd1;
                    end
                end
                else if (phase_reg != PH_DATA)
                begin
                    hdr_next[phase_reg[1:0] - 2'd1] = b;
                    phase_next = phase_reg + 3'd1;
                    if (phase_reg == 3'd3)
                    begin
                        remain_next = {b, hdr_reg[1], hdr_reg[0]};
                        idx_next = '0;
                        for (int i = 0; i < 8; i++)
                            field_next[i] = '0;
                        if ({b, hdr_reg[1], hdr_reg[0]} == 24'd0)
                        begin
                            cpend_next = 1'b1;
                            phase_next = PH_TYPE;
                        end
                    end
                end
                else
                begin
                    if (!idx_reg[3])
                        field_next[idx_reg[2:0]] = b;
                    if (!idx_reg[3])
                        idx_next = idx_reg + 4'd1;
                    remain_next = remain_reg - 24'd1;
                    if (remain_reg == 24'd1)
                    begin
                        cpend_next = 1'b1;
                        phase_next = PH_TYPE;
                    end
                end
            end
            if (pos_reg != 32'hFFFF_FFFF)
                pos_next = pos_reg + 32'd1;
        end

        if (cmd.commit)
        begin
            cpend_next = 1'b0;
            case (type_reg)
                BT_SOUND:
                begin
                    if (codec_reg == CODEC_NONE || codec_reg == {9'd0, field_reg[1]})
                    begin
                        rate_next = {4'd0, quotient};
                        chan_next = 9'd1;
                        new_codec = {9'd0, field_reg[1]};
                        codec_next = new_codec;
                        if (new_codec == CODEC_PCM8)
                            bits_next = 8'd8;
                        else if (new_codec == CODEC_PCM16)
                            bits_next = 8'd16;
                        else
                            okay_next = 1'b0;
                        len_next = len_reg + size32 - 32'd2;
                    end
                    else
                        okay_next = 1'b0;
                end
                BT_CONT:
                begin
                    if (codec_reg == CODEC_NONE)
                        okay_next = 1'b0;
                    len_next = len_reg + size32;
                end
                BT_SILENCE:
                begin
                    if (rate_reg == {4'd0, quotient})
                    begin
                        if (codec_reg == CODEC_PCM8)
                            len_next = len_reg + {15'd0, silence};
                        else if (codec_reg == CODEC_PCM16)
                            len_next = len_reg + {14'd0, silence, 1'b0};
                        else
                            okay_next = 1'b0;
                    end
                    else
                        okay_next = 1'b0;
                end
                BT_MARKER, BT_TEXT:
                begin
                end
                BT_REP_START:
                    ls_next = len_reg;
                BT_REP_END:
                begin
                    le_next = len_reg;
                    if ($signed(len_reg) < $signed(ls_reg))
                        okay_next = 1'b0;
                end
                BT_EXTENDED:
                begin
                    if (codec_reg == CODEC_NONE)
                    begin
                        codec_next = {9'd0, field_reg[2]};
                        chan_next = ch8;
                        rate_next = {4'd0, quotient};
                    end
                    else
                        okay_next = 1'b0;
                end
                BT_SOUND_NEW:
                begin
                    if (codec_reg == CODEC_NONE)
                    begin
                        rate_next = {field_reg[3], field_reg[2], field_reg[1], field_reg[0]};
                        bits_next = field_reg[4];
                        chan_next = {1'b0, field_reg[5]};
                        new_codec = {1'b0, field_reg[7], field_reg[6]};
                        codec_next = new_codec;
                        if (new_codec == CODEC_PCM8)
                            bits_next = 8'd8;
                        else if (new_codec == CODEC_PCM16)
                            bits_next = 8'd16;
                        else
                            okay_next = 1'b0;
                        len_next = len_reg + size32 - 32'd12;
                    end
                    else
                        okay_next = 1'b0;
                end
                default:
                    okay_next = 1'b0;
            endcase
        end

        if (cmd.finish)
        begin
            ovalid_next = 1'b1;
            oitem_next.accepted = okay_reg && (len_reg != 32'd0) && !len_reg[31];
            oitem_next.format_ok = okay_reg;
            oitem_next.sample_rate = rate_reg;
            oitem_next.channel_count = chan_reg;
            oitem_next.sample_bits = bits_reg;
            oitem_next.sample_length = len_reg;
            oitem_next.loop_start = ls_reg;
            oitem_next.loop_end = le_reg;
            pos_next = '0;
            sig_next = 1'b1;
            type_next = '0;
            remain_next = '0;
            idx_next = '0;
            phase_next = PH_TYPE;
            for (int i = 0; i < 8; i++)
                field_next[i] = '0;
            codec_next = CODEC_NONE;
            rate_next = '0;
            chan_next = '0;
            bits_next = '0;
            len_next = '0;
            ls_next = '1;
            le_next = '1;
            okay_next = 1'b1;
            stop_next = 1'b0;
            cpend_next = 1'b0;
            lpend_next = 1'b0;
        end
    end

    // Control and parse state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            sig_reg <= 1'b1;
            type_reg <= '0;
            remain_reg <= '0;
            idx_reg <= '0;
            phase_reg <= PH_TYPE;
            for (int i = 0; i < 8; i++)
                field_reg[i] <= '0;
            codec_reg <= CODEC_NONE;
            rate_reg <= '0;
            chan_reg <= '0;
            bits_reg <= '0;
            len_reg <= '0;
            ls_reg <= '1;
            le_reg <= '1;
            okay_reg <= 1'b1;
            stop_reg <= 1'b0;
            cpend_reg <= 1'b0;
            lpend_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            sig_reg <= sig_next;
            type_reg <= type_next;
            remain_reg <= remain_next;
            idx_reg <= idx_next;
            phase_reg <= phase_next;
            field_reg <= field_next;
            codec_reg <= codec_next;
            rate_reg <= rate_next;
            chan_reg <= chan_next;
            bits_reg <= bits_next;
            len_reg <= len_next;
            ls_reg <= ls_next;
            le_reg <= le_next;
            okay_reg <= okay_next;
            stop_reg <= stop_next;
            cpend_reg <= cpend_next;
            lpend_reg <= lpend_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Header size bytes and the result payload.
    always_ff @(posedge clk)
    begin
        hdr_reg <= hdr_next;
        oitem_reg <= oitem_next;
    end

    assign status.commit_pend = cpend_reg;
    assign status.last_pend = lpend_reg;
    assign status.need_div = (type_reg == BT_SOUND) || (type_reg == BT_SILENCE) ||
                             (type_reg == BT_EXTENDED);
    assign status.div_busy = div_busy;
    assign status.out_full = ovalid_reg;
    assign out_valid = ovalid_reg;
    assign out_item = oitem_reg;

    `VBHP_ASSERT_NEXT(a_finish_loads, cmd.finish, ovalid_reg, "finish did not load a result")
    `VBHP_ASSERT_NEXT(a_div_runs, cmd.div_start, div_busy, "divider did not start")
    `VBHP_ASSERT_NOW(a_step_alone, cmd.step, !cmd.commit && !cmd.finish, "step overlaps commit")

endmodule

FILE: hw/rtl/vbhp_ctrl.sv
// Controller state machine sequencing byte steps, commits and results.
module vbhp_ctrl
    import vbhp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    out_ready,
    input  status_t status,
    output logic    in_ready,
    output cmd_t    cmd
);

`include "voc_block_header_parser_assert.svh"

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid && in_ready)
                    state_next = ST_DECIDE;
            ST_DECIDE:
                if (status.commit_pend && status.need_div)
                    state_next = ST_LOAD;
                else if (status.commit_pend)
                    state_next = ST_COMMIT;
                else if (status.last_pend)
                    state_next = ST_FINISH;
                else
                    state_next = ST_IDLE;
            ST_LOAD:
                state_next = ST_START;
            ST_START:
                state_next = ST_DIVIDE;
            ST_DIVIDE:
                if (!status.div_busy)
                    state_next = ST_COMMIT;
            ST_COMMIT:
                if (status.last_pend)
                    state_next = ST_FINISH;
                else
                    state_next = ST_IDLE;
            ST_FINISH:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Outputs: an item is only taken in idle and once the result register can drain.
    always_comb
    begin
        in_ready = (state_reg == ST_IDLE) && (!status.out_full || out_ready);
        cmd.step = in_valid && in_ready;
        cmd.load = (state_reg == ST_LOAD);
        cmd.div_start = (state_reg == ST_START);
        cmd.commit = (state_reg == ST_COMMIT);
        cmd.finish = (state_reg == ST_FINISH);
    end

    `VBHP_ASSERT_NOW(a_ready_idle, in_ready, state_reg == ST_IDLE, "ready outside idle")
    `VBHP_ASSERT_NEXT(a_commit_once, cmd.commit, !cmd.commit, "commit lasted two cycles")
    `VBHP_ASSERT_NEXT(a_step_decides, cmd.step, state_reg == ST_DECIDE, "step not followed by decide")

endmodule

FILE: hw/rtl/voc_block_header_parser.sv
// Top level of the sound file block header parser.
// Result: the last item passes the decide and finish states before the result is
// registered; a completed block adds a commit, and a rate division adds the load,
// start and divide states of the radix-2 divider. Items are taken only in idle.
// Reset: asynchronous active low; returns the parser to its start-of-file state,
// which it also does by itself after each result.
module voc_block_header_parser
    import vbhp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    output logic      byte_ready,
    input  vbhp_in_t  byte_item,
    output logic      result_valid,
    input  logic      result_ready,
    output vbhp_out_t result_item
);

    cmd_t    cmd;
    status_t status;

    vbhp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (byte_valid),
        .out_ready (result_ready),
        .status    (status),
        .in_ready  (byte_ready),
        .cmd       (cmd)
    );

    vbhp_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_item   (byte_item),
        .out_ready (result_ready),
        .status    (status),
        .out_valid (result_valid),
        .out_item  (result_item)
    );

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the sound file block header parser.
`timescale 1ns / 100ps

module tb_top;
    import vbhp_pkg::*;

    localparam int TARGET_BYTES = 1550;
    localparam int IDLE_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 60;

    logic      clk;
    logic      rst_n;
    logic      byte_valid;
    logic      byte_ready;
    vbhp_in_t  byte_item;
    logic      result_valid;
    logic      result_ready;
    vbhp_out_t result_item;

    voc_block_header_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .byte_item    (byte_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item)
    );

    // Stimulus queues: the bytes to send, and a flag asking the sender to drain first.
    vbhp_in_t  pending_bytes[$];
    bit        drain_before[$];
    vbhp_out_t expected_summaries[$];
    bit [7:0]  file_buf[$];
    int        error_count;
    int        idle_cycles;
    int        send_gap;
    int        recv_stall;
    bit        stim_done;
    bit [7:0]  last_rate_code;

    // Mirror of the parser state.
    bit [31:0] p_pos;
    bit        p_sig_ok;
    bit [7:0]  p_hdr[3];
    bit [7:0]  p_btype;
    bit [23:0] p_remain;
    bit [7:0]  p_fld[8];
    bit [16:0] p_codec;
    bit [31:0] p_rate;
    bit [8:0]  p_chans;
    bit [7:0]  p_bits;
    bit [31:0] p_len;
    bit [31:0] p_loop_start;
    bit [31:0] p_loop_end;
    bit        p_ok;
    bit        p_stopped;
    bit [2:0]  p_phase;
    bit [31:0] p_didx;

    // Clock.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("MISMATCH at %0t: %s got %h expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic void clear_parser();
        p_pos = '0;
        p_sig_ok = 1'b1;
        p_hdr = '{default: 8'h00};
        p_btype = BT_END;
        p_remain = '0;
        p_fld = '{default: 8'h00};
        p_codec = CODEC_NONE;
        p_rate = '0;
        p_chans = '0;
        p_bits = '0;
        p_len = '0;
        p_loop_start = '1;
        p_loop_end = '1;
        p_ok = 1'b1;
        p_stopped = 1'b0;
        p_phase = PH_TYPE;
        p_didx = '0;
    endfunction

    function automatic void bits_from_codec();
        if (p_codec == CODEC_PCM8)
            p_bits = 8'd8;
        else if (p_codec == CODEC_PCM16)
            p_bits = 8'd16;
        else
            p_ok = 1'b0;
    endfunction

    // Apply one complete block to the summary registers.
    function automatic void commit_block(input bit [31:0] size);
        bit [31:0] tc;
        bit [31:0] sil;
        case (p_btype)
            BT_SOUND:
            begin
                if (p_codec == CODEC_NONE || p_codec == {9'd0, p_fld[1]})
                begin
                    p_rate = 32'd1000000 / (32'd256 - 32'(p_fld[0]));
                    p_chans = 9'd1;
                    p_codec = {9'd0, p_fld[1]};
                    bits_from_codec();
                    p_len = p_len + size - 32'd2;
                end
                else
                    p_ok = 1'b0;
            end
            BT_CONT:
            begin
                if (p_codec == CODEC_NONE)
                    p_ok = 1'b0;
                p_len = p_len + size;
            end
            BT_SILENCE:
            begin
                if (p_rate == 32'd1000000 / (32'd256 - 32'(p_fld[2])))
                begin
                    sil = 32'd1 + 32'(p_fld[0]) + (32'(p_fld[1]) << 8);
                    if (p_codec == CODEC_PCM8)
                        p_len = p_len + sil;
                    else if (p_codec == CODEC_PCM16)
                        p_len = p_len + (sil << 1);
                    else
                        p_ok = 1'b0;
                end
                else
                    p_ok = 1'b0;
            end
            BT_MARKER, BT_TEXT: ;
            BT_REP_START: p_loop_start = p_len;
            BT_REP_END:
            begin
                p_loop_end = p_len;
                if ($signed(p_loop_end) < $signed(p_loop_start))
                    p_ok = 1'b0;
            end
            BT_EXTENDED:
            begin
                if (p_codec == CODEC_NONE)
                begin
                    tc = {16'd0, p_fld[1], p_fld[0]};
                    p_codec = {9'd0, p_fld[2]};
                    p_chans = 9'd1 + 9'(p_fld[3]);
                    p_rate = 32'd256000000 / (32'(p_chans) * (32'd65536 - tc));
                end
                else
                    p_ok = 1'b0;
            end
            BT_SOUND_NEW:
            begin
                if (p_codec == CODEC_NONE)
                begin
                    p_rate = {p_fld[3], p_fld[2], p_fld[1], p_fld[0]};
                    p_bits = p_fld[4];
                    p_chans = 9'(p_fld[5]);
                    p_codec = {1'b0, p_fld[7], p_fld[6]};
                    bits_from_codec();
                    p_len = p_len + size - 32'd12;
                end
                else
                    p_ok = 1'b0;
            end
            default: p_ok = 1'b0;
        endcase
    endfunction

    function automatic void parse_block_byte(input bit [7:0] b);
        if (p_phase == PH_TYPE)
        begin
            if (b == BT_END)
                p_stopped = 1'b1;
            else
            begin
                p_btype = b;
                p_phase = 3'd1;
            end
        end
        else if (p_phase < PH_DATA)
        begin
            p_hdr[2'(p_phase - 3'd1)] = b;
            p_phase++;
            if (p_phase == PH_DATA)
            begin
                p_remain = {p_hdr[2], p_hdr[1], p_hdr[0]};
                p_didx = '0;
                p_fld = '{default: 8'h00};
                if (p_remain == '0)
                begin
                    commit_block(32'd0);
                    p_phase = PH_TYPE;
                end
            end
        end
        else
        begin
            if (p_didx < 8)
                p_fld[p_didx[2:0]] = b;
            p_didx++;
            p_remain = p_remain - 24'd1;
            if (p_remain == '0)
            begin
                commit_block({8'd0, p_hdr[2], p_hdr[1], p_hdr[0]});
                p_phase = PH_TYPE;
            end
        end
    endfunction

    // Advance the mirror by one accepted item; queue a summary on the last byte.
    function automatic void predict_byte(input vbhp_in_t it);
        vbhp_out_t s;
        if (p_pos < SIG_LEN)
        begin
            if (it.file_byte != SIG_BYTES[p_pos[4:0]])
                p_sig_ok = 1'b0;
        end
        else if (p_pos >= DATA_START && p_sig_ok && !p_stopped)
            parse_block_byte(it.file_byte);
        if (p_pos != '1)
            p_pos++;
        if (it.last_byte)
        begin
            s.accepted = p_ok && p_len != '0 && !p_len[31];
            s.format_ok = p_ok;
            s.sample_rate = p_rate;
            s.channel_count = p_chans;
            s.sample_bits = p_bits;
            s.sample_length = p_len;
            s.loop_start = p_loop_start;
            s.loop_end = p_loop_end;
            expected_summaries.push_back(s);
            clear_parser();
        end
    endfunction

    // File building helpers.
    task automatic begin_file(input bit good_sig);
        int k;
        for (k = 0; k < SIG_LEN; k++)
            file_buf.push_back(SIG_BYTES[5'(k)]);
        if (!good_sig)
            file_buf[$urandom_range(0, SIG_LEN - 1)] ^= 8'(1 << $urandom_range(0, 7));
        for (k = SIG_LEN; k < DATA_START; k++)
            file_buf.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic add_block(input bit [7:0] bt, input int size);
        int k;
        bit [7:0] v;
        file_buf.push_back(bt);
        file_buf.push_back(size[7:0]);
        file_buf.push_back(size[15:8]);
        file_buf.push_back(size[23:16]);
        for (k = 0; k < size; k++)
        begin
            v = 8'($urandom_range(0, 255));
            // Bias codec bytes toward the two valid codes, and keep silence at the rate.
            if ((bt == BT_SOUND && k == 1) || (bt == BT_EXTENDED && k == 2) ||
                (bt == BT_SOUND_NEW && k == 6))
                v = ($urandom_range(0, 3) == 0) ? v : ($urandom_range(0, 1) ? 8'd4 : 8'd0);
            if (bt == BT_SOUND_NEW && k == 7 && $urandom_range(0, 3) != 0)
                v = 8'd0;
            if (bt == BT_SOUND && k == 0)
                last_rate_code = v;
            if (bt == BT_SILENCE && k == 2 && $urandom_range(0, 3) != 0)
                v = last_rate_code;
            file_buf.push_back(v);
        end
    endtask

    task automatic finish_file(input bit drain);
        int k;
        vbhp_in_t it;
        for (k = 0; k < file_buf.size(); k++)
        begin
            it.file_byte = file_buf[k];
            it.last_byte = (k == file_buf.size() - 1);
            pending_bytes.push_back(it);
            drain_before.push_back(drain && k == 0);
        end
        file_buf.delete();
    endtask

    task automatic random_file();
        int nblk;
        int b;
        int r;
        int size;
        bit [7:0] bt;
        begin_file($urandom_range(0, 9) != 0);
        nblk = $urandom_range(0, 5);
        for (b = 0; b < nblk; b++)
        begin
            r = $urandom_range(0, 99);
            if (b == 0 && r < 70)
            begin
                bt = (r < 35) ? BT_SOUND : (r < 50) ? BT_EXTENDED : BT_SOUND_NEW;
            end
            else if (r < 20) bt = BT_SOUND;
            else if (r < 35) bt = BT_CONT;
            else if (r < 47) bt = BT_SILENCE;
            else if (r < 55) bt = BT_REP_START;
            else if (r < 63) bt = BT_REP_END;
            else if (r < 70) bt = BT_EXTENDED;
            else if (r < 77) bt = BT_SOUND_NEW;
            else if (r < 83) bt = $urandom_range(0, 1) ? BT_MARKER : BT_TEXT;
            else if (r < 88) bt = 8'($urandom_range(10, 255));
            else bt = 8'($urandom_range(1, 255));
            case (bt)
                BT_SOUND: size = $urandom_range(0, 6);
                BT_SILENCE: size = $urandom_range(2, 4);
                BT_EXTENDED: size = $urandom_range(3, 5);
                BT_SOUND_NEW: size = $urandom_range(10, 16);
                default: size = $urandom_range(0, 10);
            endcase
            add_block(bt, size);
        end
        r = $urandom_range(0, 9);
        if (r < 2)
        begin
            // End marker followed by ignored bytes.
            file_buf.push_back(BT_END);
            repeat ($urandom_range(0, 4)) file_buf.push_back(8'($urandom_range(0, 255)));
        end
        else if (r < 4)
        begin
            // Header that promises more data than the file holds.
            file_buf.push_back(8'($urandom_range(1, 9)));
            repeat ($urandom_range(0, 3)) file_buf.push_back(8'($urandom_range(0, 255)));
            repeat ($urandom_range(0, 6)) file_buf.push_back(8'($urandom_range(0, 255)));
        end
        finish_file($urandom_range(0, 19) == 0);
    endtask

    // Sender: one item per handshake, with random gaps and optional drain pauses.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
            byte_item <= '0;
            send_gap <= 0;
        end
        else if (!byte_valid || byte_ready)
        begin
            if (byte_valid)
                predict_byte(byte_item);
            if (send_gap > 0)
            begin
                byte_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_bytes.size() > 0 &&
                     !(drain_before[0] && expected_summaries.size() > 0) &&
                     !(drain_before[0] && byte_valid && byte_item.last_byte))
            begin
                byte_valid <= 1'b1;
                byte_item <= pending_bytes.pop_front();
                void'(drain_before.pop_front());
                send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            end
            else
                byte_valid <= 1'b0;
        end
    end

    // Receiver: random stalls, then compare each summary with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            recv_stall <= 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_summaries.size() == 0)
                begin
                    $display("MISMATCH at %0t: summary with none expected", $realtime);
                    error_count++;
                end
                else
                begin
                    vbhp_out_t w;
                    w = expected_summaries.pop_front();
                    if (result_item.accepted !== w.accepted)
                        report("accepted", result_item.accepted, w.accepted);
                    if (result_item.format_ok !== w.format_ok)
                        report("format_ok", result_item.format_ok, w.format_ok);
                    if (result_item.sample_rate !== w.sample_rate)
                        report("sample_rate", result_item.sample_rate, w.sample_rate);
                    if (result_item.channel_count !== w.channel_count)
                        report("channel_count", result_item.channel_count, w.channel_count);
                    if (result_item.sample_bits !== w.sample_bits)
                        report("sample_bits", result_item.sample_bits, w.sample_bits);
                    if (result_item.sample_length !== w.sample_length)
                        report("sample_length", result_item.sample_length, w.sample_length);
                    if (result_item.loop_start !== w.loop_start)
                        report("loop_start", result_item.loop_start, w.loop_start);
                    if (result_item.loop_end !== w.loop_end)
                        report("loop_end", result_item.loop_end, w.loop_end);
                end
                recv_stall <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                result_ready <= 1'b0;
            end
            else if (recv_stall > 0)
            begin
                recv_stall <= recv_stall - 1;
                result_ready <= 1'b0;
            end
            else
                result_ready <= 1'b1;
        end
    end

    // Watchdog on cycles without any accepted item or result.
    always @(posedge clk)
    begin
        if (!rst_n || (byte_valid && byte_ready) || (result_valid && result_ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        error_count = 0;
        idle_cycles = 0;
        stim_done = 1'b0;
        last_rate_code = 8'd0;
        clear_parser();
        rst_n = 1'b0;

        // Directed files: short files, bad signature, end marker and the odd block types.
        begin_file(1'b1);
        repeat (DATA_START - 5) void'(file_buf.pop_back());
        finish_file(1'b0);
        begin_file(1'b1);
        finish_file(1'b0);
        begin_file(1'b0);
        add_block(BT_SOUND, 4);
        finish_file(1'b0);
        begin_file(1'b1);
        file_buf.push_back(8'hFF);
        file_buf.push_back(8'h00);
        file_buf.push_back(8'h00);
        file_buf.push_back(8'h00);
        file_buf.push_back(BT_END);
        file_buf.push_back(8'hFF);
        finish_file(1'b0);
        begin_file(1'b1);
        add_block(BT_SOUND, 0);
        add_block(BT_MARKER, 1);
        add_block(BT_TEXT, 0);
        add_block(BT_REP_START, 0);
        add_block(BT_REP_END, 0);
        finish_file(1'b1);
        begin_file(1'b1);
        add_block(BT_SOUND_NEW, 1);
        add_block(BT_CONT, 3);
        add_block(BT_SILENCE, 3);
        add_block(BT_EXTENDED, 4);
        add_block(8'd10, 2);
        finish_file(1'b0);
        begin_file(1'b1);
        add_block(BT_EXTENDED, 4);
        add_block(BT_SOUND, 2);
        finish_file(1'b0);

        while (pending_bytes.size() < TARGET_BYTES)
            random_file();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_bytes.size() == 0);
        @(posedge clk);
        while (byte_valid)
            @(posedge clk);
        while (expected_summaries.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/vbhp_pkg.sv
hw/rtl/vbhp_div.sv
hw/rtl/vbhp_dp.sv
hw/rtl/vbhp_ctrl.sv
hw/rtl/voc_block_header_parser.sv
tb/tb_top.sv
